[rtl/uda_pkg.sv]
// ----------------------------------------------------------------------------
// uda_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package uda_pkg;

  localparam int VALUE_W = 32;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 6;

  // q = (v * DIV10_MAGIC) >> DIV10_SHIFT equals v / 10 for every 32-bit v
  localparam logic [VALUE_W-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int                 DIV10_SHIFT = 35;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic load;   // capture new value, clear digit count
    logic step;   // store one remainder digit, keep quotient
    logic emit;   // move top stored digit into output register
  } dp_cmd_t;

  typedef struct packed {
    logic quot_zero;  // quotient of current step is zero
    logic cnt_full;   // current step fills the digit store
    logic cnt_one;    // one digit left to emit
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/uint_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// uint_to_decimal_ascii
// 32-bit unsigned value to decimal ASCII digits, most significant first.
// ----------------------------------------------------------------------------
// Conversion: after an input transfer, one divide-by-ten step per cycle, one
// step per digit, n = digit count (1..min(10, MAX_DIGITS)); then the digits are
// emitted, held while out_tready is low. A new value is accepted only after the
// last digit has entered the output register.
// Reset: synchronous, active low; clears controller and counters.
`default_nettype none

module uint_to_decimal_ascii
  import uda_pkg::*;
#(
  parameter int MAX_DIGITS = 10
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [5:0] digit_char, [7:6] zero
  output logic             out_tlast   // last_digit
);

  dp_cmd_t           cmd;
  dp_status_t        st;
  logic [CHAR_W-1:0] digit_char;

  uda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .st        (st)
  );

  uda_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .value      (in_tdata),
    .digit_char (digit_char),
    .last_digit (out_tlast)
  );

  assign out_tdata = {2'b00, digit_char};

endmodule

`default_nettype wire

[rtl/uda_ctrl.sv]
// ----------------------------------------------------------------------------
// uda_ctrl
// Sequencer: accept a value, run the divide-by-ten steps, emit the digits.
// ----------------------------------------------------------------------------
`default_nettype none

module uda_ctrl
  import uda_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output dp_cmd_t         cmd,
  input  wire dp_status_t st
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (st.quot_zero || st.cnt_full) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (st.cnt_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[rtl/uda_datapath.sv]
// ----------------------------------------------------------------------------
// uda_datapath
// Divide-by-ten step unit, digit store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module uda_datapath
  import uda_pkg::*;
#(
  parameter int MAX_DIGITS = 10
)
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_status_t              st,
  input  wire logic [VALUE_W-1:0] value,
  output logic      [CHAR_W-1:0]  digit_char,
  output logic                    last_digit
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [VALUE_W-1:0] rem_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [DIGIT_W-1:0] store [MAX_DIGITS];
  logic [CHAR_W-1:0]  char_r;
  logic               last_r;

  logic [2*VALUE_W-1:0] prod;
  logic [2*VALUE_W-1:0] prod_sh;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   ten_quot;
  logic [VALUE_W-1:0]   diff;
  logic [DIGIT_W-1:0]   digit;
  logic [CW-1:0]        cnt_dec;
  logic [IW-1:0]        wr_idx;
  logic [IW-1:0]        rd_idx;

  assign prod     = {{VALUE_W{1'b0}}, rem_r} * {{VALUE_W{1'b0}}, DIV10_MAGIC};
  assign prod_sh  = prod >> DIV10_SHIFT;
  assign quot     = prod_sh[VALUE_W-1:0];
  assign ten_quot = {quot[VALUE_W-4:0], 3'b000} + {quot[VALUE_W-2:0], 1'b0};
  assign diff     = rem_r - ten_quot;
  assign digit    = diff[DIGIT_W-1:0];

  assign cnt_dec = cnt_r - CW'(1);
  assign wr_idx  = cnt_r[IW-1:0];
  assign rd_idx  = cnt_dec[IW-1:0];

  assign st.quot_zero = (quot == '0);
  assign st.cnt_full  = (cnt_r == CW'(MAX_DIGITS - 1));
  assign st.cnt_one   = (cnt_r == CW'(1));

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (cmd.load) begin
      cnt_nxt = '0;
    end else if (cmd.step) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.emit) begin
      cnt_nxt = cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (cmd.load) begin
      rem_r <= value;
    end else if (cmd.step) begin
      rem_r <= quot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      store[wr_idx] <= digit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      char_r <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, store[rd_idx]};
      last_r <= (cnt_r == CW'(1));
    end
  end

  assign digit_char = char_r;
  assign last_digit = last_r;

endmodule

`default_nettype wire

[rtl/uda_checker.sv]
// ----------------------------------------------------------------------------
// uda_checker
// Port-level checks for the decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

module uda_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast
);

  // stalled output transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:4] == 4'h3) && (out_tdata[3:0] <= 4'd9))
    else $error("output is not a decimal digit");

  // converter is busy right after taking a value
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted two values back to back");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind uint_to_decimal_ascii uda_checker u_uda_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[dv/uint_to_decimal_ascii_checker.sv]
// ----------------------------------------------------------------------------
// uint_to_decimal_ascii_checker
// Watches both stream channels of the decimal ASCII converter. Every input
// transfer is converted to its expected digit sequence, most significant
// first. Each output transfer is compared against the oldest pending digit.
// ----------------------------------------------------------------------------
module uint_to_decimal_ascii_checker
  import uda_pkg::*;
#(
  parameter int MAX_DIGITS = 10
)
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_tready,
  input  wire logic [VALUE_W-1:0] in_tdata,    // [31:0] value
  input  wire logic               out_tvalid,
  input  wire logic               out_tready,
  input  wire logic [7:0]         out_tdata,   // [5:0] digit_char, [7:6] zero
  input  wire logic               out_tlast,   // last_digit
  output int                      errors,
  output int                      outstanding
);

  localparam int RADIX = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } digit_t;

  digit_t expected_digits[$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Repeated divide by ten into a local digit store, then queue the digits
  // in reverse order; the store depth caps the digit count.
  task automatic predict_digits(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] stored[MAX_DIGITS];
    int                 n;
    digit_t             d;
    quotient = value;
    n = 0;
    do begin
      stored[n] = DIGIT_W'(quotient % RADIX);
      quotient  = quotient / RADIX;
      n++;
    end while (quotient != 0 && n < MAX_DIGITS);
    for (int k = n; k > 0; k--) begin
      d.digit_char = CHAR_W'(stored[k-1]) + ASCII_ZERO;
      d.last_digit = (k == 1);
      expected_digits.push_back(d);
    end
  endtask

  always @(posedge clk) begin : watch
    digit_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_digits.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer tdata=0x%02h tlast=%b",
                                    out_tdata, out_tlast));
        end else begin
          want = expected_digits.pop_front();
          if (out_tdata[CHAR_W-1:0] !== want.digit_char) begin
            report_mismatch($sformatf("digit_char 0x%02h, expected 0x%02h",
                                      out_tdata[CHAR_W-1:0], want.digit_char));
          end
          if (out_tdata[7:CHAR_W] !== '0) begin
            report_mismatch($sformatf("tdata pad bits %b, expected zero",
                                      out_tdata[7:CHAR_W]));
          end
          if (out_tlast !== want.last_digit) begin
            report_mismatch($sformatf("last_digit %b, expected %b",
                                      out_tlast, want.last_digit));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_digits(in_tdata);
      end
    end
    outstanding <= expected_digits.size();
  end

endmodule

[dv/uint_to_decimal_ascii_test.sv]
// ----------------------------------------------------------------------------
// uint_to_decimal_ascii_test
// Top of the converter testbench. Drives corner values, then random values
// spread over every digit length, under three sender/receiver idling mixes.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module uint_to_decimal_ascii_test;
  import uda_pkg::*;

  localparam int MAX_DIGITS   = 10;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_ITEMS  = 107;
  localparam int SETTLE_CYCLES = 40;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;
  logic               out_tlast;

  int errors;
  int outstanding;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  logic [VALUE_W-1:0] corner_values[] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101, 32'd1000009,
    32'd999999999, 32'd1000000000, 32'd1234567890, 32'd2147483647,
    32'd2147483648, 32'd4000000000, 32'd4294967294, 32'd4294967295,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000,
    32'd10000, 32'd90000000, 32'd5
  };

  uint_to_decimal_ascii #(
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  uint_to_decimal_ascii_checker #(
    .MAX_DIGITS(MAX_DIGITS)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .errors     (errors),
    .outstanding(outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic send_value(input logic [VALUE_W-1:0] value);
    int gap;
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // hold the input until every pending digit has been transferred
  task automatic wait_drained;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // mostly a uniform digit length, then a uniform value of that length
  function automatic logic [VALUE_W-1:0] random_value;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned scale;
    longint unsigned r;
    int              len;
    r = $urandom();
    if ($urandom_range(0, 4) == 0) return VALUE_W'(r);
    len = $urandom_range(1, 10);
    scale = 1;
    repeat (len - 1) scale = scale * 10;
    lo = (len == 1) ? 0 : scale;
    hi = scale * 10 - 1;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return VALUE_W'(lo + r % (hi - lo + 1));
  endfunction

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    tx_idle_pct = 37;
    rx_idle_pct = 84;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_values[i]) send_value(corner_values[i]);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 37;
          rx_idle_pct = 84;
        end
        1: begin
          tx_idle_pct = 84;
          rx_idle_pct = 37;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) send_value(random_value());
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
